@@ hdl/fpsrs_pkg.sv @@
// Shared types and constants for the Fenwick point-set / range-sum block.
// No dependencies; every other file in hdl/ imports this package.
package fpsrs_pkg;

    localparam int POS_W    = 11;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 64;
    localparam int STATUS_W = 2;

    localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_SET   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUERY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VAL_RD,
        ST_DELTA,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TREE_UPD,
        OP_ACC_ADD,
        OP_ACC_SUB
    } tree_op_t;

    // Sequencer to datapath command bundle
    typedef struct packed {
        logic     clr;
        logic     capture;
        logic     val_rd;
        logic     delta;
        logic     tree_rd;
        tree_op_t op;
        logic     acc_clr;
    } dp_ctl_t;

endpackage

@@ hdl/fpsrs_dp.sv @@
// Datapath: value and tree memories, the shared 64-bit add/subtract unit,
// the accumulator and the delta register. Depends on fpsrs_pkg.
module fpsrs_dp
    import fpsrs_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_ctl_t                  ctl,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [VAL_W-1:0]         new_value,
    output logic [SUM_W-1:0]         acc
);

    localparam int A_W = $clog2(DEPTH);

    logic [VAL_W-1:0] value_mem [DEPTH];
    logic [SUM_W-1:0] tree_mem  [DEPTH];

    logic [VAL_W-1:0] nv_reg;
    logic [VAL_W-1:0] val_q_reg;
    logic [SUM_W-1:0] tree_q_reg;
    logic [SUM_W-1:0] delta_reg;
    logic [SUM_W-1:0] acc_reg;
    tree_op_t         pend_op_reg;
    logic [A_W-1:0]   pend_addr_reg;

    logic [SUM_W-1:0] op_a;
    logic [SUM_W-1:0] op_b;
    logic             op_sub;
    logic [SUM_W-1:0] sum;

    // Shared adder: operands picked by the command in flight
    always_comb
    begin
        op_a   = acc_reg;
        op_b   = '0;
        op_sub = 1'b0;
        if (ctl.delta)
        begin
            op_a   = {{(SUM_W-VAL_W){nv_reg[VAL_W-1]}}, nv_reg};
            op_b   = {{(SUM_W-VAL_W){val_q_reg[VAL_W-1]}}, val_q_reg};
            op_sub = 1'b1;
        end
        else
        begin
            case (pend_op_reg)
                OP_TREE_UPD:
                begin
                    op_a = tree_q_reg;
                    op_b = delta_reg;
                end
                OP_ACC_ADD:
                begin
                    op_b = tree_q_reg;
                end
                OP_ACC_SUB:
                begin
                    op_b   = tree_q_reg;
                    op_sub = 1'b1;
                end
                default:
                begin
                    op_b = '0;
                end
            endcase
        end
        sum = op_a + (op_b ^ {SUM_W{op_sub}}) + SUM_W'(op_sub);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
            value_mem[addr] <= '0;
        else if (ctl.delta)
            value_mem[addr] <= nv_reg;
        if (ctl.val_rd)
            val_q_reg <= value_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
            tree_mem[addr] <= '0;
        else if (pend_op_reg == OP_TREE_UPD)
            tree_mem[pend_addr_reg] <= sum;
        if (ctl.tree_rd)
            tree_q_reg <= tree_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
            nv_reg <= new_value;
        if (ctl.delta)
            delta_reg <= sum;
        if (ctl.acc_clr)
            acc_reg <= '0;
        else if (pend_op_reg == OP_ACC_ADD || pend_op_reg == OP_ACC_SUB)
            acc_reg <= sum;
        if (ctl.tree_rd)
            pend_addr_reg <= addr;
    end

    // The node read this cycle is folded in next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_op_reg <= OP_NONE;
        else
            pend_op_reg <= ctl.tree_rd ? ctl.op : OP_NONE;
    end

    assign acc = acc_reg;

`ifndef SYNTHESIS
    a_delta_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.delta |-> pend_op_reg == OP_NONE)
        else $error("delta computed while a tree operation is pending");

    a_clear_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |-> (pend_op_reg == OP_NONE && !ctl.tree_rd))
        else $error("clearing pass overlaps tree traffic");
`endif

endmodule

@@ hdl/fpsrs_ctrl.sv @@
// Sequencer: clearing pass, range checks, set and query tree walks.
// Drives fpsrs_dp through a dp_ctl_t bundle. Depends on fpsrs_pkg.
module fpsrs_ctrl
    import fpsrs_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [POS_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_action,
    input  logic [POS_W-1:0]         in_pos,
    input  logic [POS_W-1:0]         in_last,
    input  logic                     out_free,
    output logic                     done,
    output logic [STATUS_W-1:0]      done_status,
    output dp_ctl_t                  ctl,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int A_W    = $clog2(DEPTH);
    localparam int WALK_W = $clog2(2 * DEPTH + 1);
    localparam int P_W    = (WALK_W > POS_W) ? WALK_W : POS_W;
    localparam logic [P_W-1:0] DEPTH_P  = P_W'(DEPTH);
    localparam logic [A_W-1:0] LAST_ADR = A_W'(DEPTH - 1);

    state_t              state_reg,  state_next;
    logic [P_W-1:0]      ptr_reg,    ptr_next;
    logic [P_W-1:0]      first_reg,  first_next;
    logic                phase_reg,  phase_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [A_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]    size_reg;

    logic [P_W-1:0] size_ext;
    logic [P_W-1:0] used;
    logic [P_W-1:0] pos_ext;
    logic [P_W-1:0] last_ext;
    logic           pos_ok;
    logic           last_ok;
    logic [P_W-1:0] low;
    logic [P_W-1:0] ptr_up;
    logic [P_W-1:0] ptr_dn;
    logic           accept;

    assign size_ext = P_W'(size_reg);
    assign used     = (size_ext > DEPTH_P) ? DEPTH_P : size_ext;
    assign pos_ext  = P_W'(in_pos);
    assign last_ext = P_W'(in_last);
    assign pos_ok   = (pos_ext != '0) && (pos_ext <= used);
    assign last_ok  = (last_ext != '0) && (last_ext <= used);
    assign low      = ptr_reg & (~ptr_reg + P_W'(1));
    assign ptr_up   = ptr_reg + low;
    assign ptr_dn   = ptr_reg - low;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        first_next   = first_reg;
        phase_next   = phase_reg;
        status_next  = status_reg;
        clr_cnt_next = clr_cnt_reg;
        in_ready     = 1'b0;
        done         = 1'b0;
        ctl          = '0;
        ctl.op       = OP_NONE;
        addr         = A_W'(ptr_reg - P_W'(1));

        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr      = 1'b1;
                addr         = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + A_W'(1);
                if (clr_cnt_reg == LAST_ADR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == ACT_SET)
                    begin
                        ctl.capture = 1'b1;
                        ptr_next    = pos_ext;
                        if (pos_ok)
                        begin
                            status_next = STATUS_SET;
                            state_next  = ST_VAL_RD;
                        end
                        else
                        begin
                            status_next = STATUS_ERROR;
                            state_next  = ST_DONE;
                        end
                    end
                    else
                    begin
                        ctl.acc_clr = 1'b1;
                        ptr_next    = last_ext;
                        first_next  = pos_ext - P_W'(1);
                        phase_next  = 1'b0;
                        if (pos_ok && last_ok)
                        begin
                            status_next = STATUS_QUERY;
                            state_next  = ST_WALK;
                        end
                        else
                        begin
                            status_next = STATUS_ERROR;
                            state_next  = ST_DONE;
                        end
                    end
                end
            end
            ST_VAL_RD:
            begin
                ctl.val_rd = 1'b1;
                state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                ctl.delta  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                ctl.tree_rd = 1'b1;
                if (status_reg == STATUS_SET)
                begin
                    // climb by lowest set bit up to the full depth
                    ctl.op = OP_TREE_UPD;
                    if (ptr_up > DEPTH_P)
                        state_next = ST_DRAIN;
                    else
                        ptr_next = ptr_up;
                end
                else
                begin
                    ctl.op = phase_reg ? OP_ACC_SUB : OP_ACC_ADD;
                    if (ptr_dn != '0)
                        ptr_next = ptr_dn;
                    else if (!phase_reg && first_reg != '0)
                    begin
                        phase_next = 1'b1;
                        ptr_next   = first_reg;
                    end
                    else
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done = 1'b1;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            size_reg    <= SIZE_RESET;
            status_reg  <= STATUS_SET;
            phase_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            status_reg  <= status_next;
            phase_reg   <= phase_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        first_reg <= first_next;
    end

`ifndef SYNTHESIS
    a_walk_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> (ptr_reg != '0 && ptr_reg <= DEPTH_P))
        else $error("tree walk pointer outside the stored nodes");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken again before the item finished");

    a_walk_not_error: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> status_reg != STATUS_ERROR)
        else $error("tree walk started for an out-of-range item");

    a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_cnt_reg != LAST_ADR) |=> state_reg == ST_CLEAR)
        else $error("clearing pass left early");
`endif

endmodule

@@ hdl/fenwick_point_set_range_sum.sv @@
// Top level of the Fenwick point-set / range-sum block: stream ports,
// output register, fpsrs_ctrl sequencer and fpsrs_dp datapath. Uses fpsrs_pkg.
//
//  channel | dir | handshake         | content
//  --------+-----+-------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready | tuser: action; tdata: position,
//          |     |                   |   last_position, new_value
//  m_      | out | m_tvalid/m_tready | tuser: status; tdata: range_sum
//  cfg_    | in  | cfg_we            | cfg_wdata: size_in_use
//
// A set reads the old value, forms the delta and climbs the tree (at most
// log2(DEPTH)+1 nodes); a query sums the nodes of both prefixes. The tree
// walk is paced by the one tree memory read port, one node per cycle.
// After reset a clearing pass over all addresses zeroes both stores; s_tready is
// low meanwhile. One item at a time; the next is taken while a result waits
// in the output register, and a stalled m_ side holds the finished item.
module fenwick_point_set_range_sum
    import fpsrs_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [POS_W-1:0]    cfg_wdata,      // size_in_use
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [55:0]         s_tdata,        // position, last_position, new_value, pad
    input  logic [0:0]          s_tuser,        // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SUM_W-1:0]    m_tdata,        // range_sum
    output logic [STATUS_W-1:0] m_tuser         // status
);

    localparam int A_W = $clog2(DEPTH);

    dp_ctl_t             ctl;
    logic [A_W-1:0]      addr;
    logic [SUM_W-1:0]    acc;
    logic                done;
    logic [STATUS_W-1:0] done_status;
    logic                out_free;
    logic                load;

    logic                m_tvalid_reg;
    logic [SUM_W-1:0]    m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = done && out_free;

    fpsrs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser[0]),
        .in_pos      (s_tdata[10:0]),
        .in_last     (s_tdata[21:11]),
        .out_free    (out_free),
        .done        (done),
        .done_status (done_status),
        .ctl         (ctl),
        .addr        (addr)
    );

    fpsrs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .addr      (addr),
        .new_value (s_tdata[53:22]),
        .acc       (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Sum is zero for sets and errors
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= (done_status == STATUS_QUERY) ? acc : '0;
            m_tuser_reg <= done_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
